FILE: hdl/tcse_pkg.sv
// Shared types and constants for the text console scrollback engine.
`timescale 1ns / 1ps
package tcse_pkg;

  localparam int TERMINALS_DEF    = 4;
  localparam int COLUMNS_DEF      = 80;
  localparam int ROWS_DEF         = 25;
  localparam int STORED_LINES_DEF = 128;

  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_SWITCH = 3'd1;
  localparam logic [2:0] CMD_COLOR  = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_UP     = 3'd4;
  localparam logic [2:0] CMD_DOWN   = 3'd5;
  localparam logic [2:0] CMD_READ   = 3'd6;

  localparam logic [7:0]  CHAR_NL      = 8'h0A;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;
  localparam logic [7:0]  CHAR_TAB     = 8'h09;
  localparam logic [7:0]  CHAR_BS      = 8'h08;
  localparam logic [7:0]  CHAR_BLANK   = 8'h20;
  localparam logic [7:0]  RESET_COLOUR = 8'h0F;
  localparam logic [15:0] RESET_CELL   = 16'h0F20;

  typedef enum logic [2:0] {
    OP_PUT, OP_SWITCH, OP_COLOR, OP_CLEAR, OP_UP, OP_DOWN, OP_READ, OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    CK_NL, CK_CR, CK_TAB, CK_BS, CK_PRINT
  } chr_t;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_READW, ST_BLANK, ST_CLEAR, ST_RESP
  } state_t;

  typedef struct packed {
    op_t        op;
    chr_t       kind;
    logic [7:0] ch;
    logic [3:0] sel;
    logic       sel_ok;
    logic [7:0] color;
    logic [7:0] lines;
    logic [4:0] row;
    logic [6:0] col;
    logic       rd_in;
  } item_t;

endpackage

FILE: hdl/text_console_scrollback_engine_core.sv
// Top level of the multi-terminal text console with scrollback.
// A command enters the queue, the idle executor pops it and runs it in the exec state, and the
// response state registers the outputs and done. A read adds a wait state, a put char that
// scrolls the store blanks a row, clear blanks all the terminal's stored lines. Executor: takes
// no new command until the last is done; queue 2. Reset: busy stays high while all 2^(TW+LW+CW)
// store cells (65536 at defaults) clear. done pulses one cycle per command; receiver cannot stall.
`timescale 1ns / 1ps
module text_console_scrollback_engine_core #(
  parameter int TERMINALS    = tcse_pkg::TERMINALS_DEF,
  parameter int COLUMNS      = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS         = tcse_pkg::ROWS_DEF,
  parameter int STORED_LINES = tcse_pkg::STORED_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [3:0]  terminal_sel,
  input  logic [7:0]  color_value,
  input  logic [7:0]  line_count,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  output logic        done,
  output logic [15:0] cell_word,
  output logic [6:0]  view_start_row,
  output logic [6:0]  cursor_col_out,
  output logic [4:0]  cursor_row_out,
  output logic        cursor_hidden,
  output logic [3:0]  active_term_out
);

  tcse_pkg::item_t f_item;
  tcse_pkg::item_t q_item;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  logic            init_busy;

  assign busy = q_full || init_busy;

  tcse_front #(
    .TERMINALS(TERMINALS),
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .char_code   (char_code),
    .terminal_sel(terminal_sel),
    .color_value (color_value),
    .line_count  (line_count),
    .read_row    (read_row),
    .read_col    (read_col),
    .push        (push),
    .item        (f_item)
  );

  tcse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (f_item),
    .pop      (pop),
    .item_out (q_item),
    .not_empty(q_valid),
    .full     (q_full)
  );

  tcse_back #(
    .TERMINALS   (TERMINALS),
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .STORED_LINES(STORED_LINES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (pop),
    .init_busy      (init_busy),
    .done           (done),
    .cell_word      (cell_word),
    .view_start_row (view_start_row),
    .cursor_col_out (cursor_col_out),
    .cursor_row_out (cursor_row_out),
    .cursor_hidden  (cursor_hidden),
    .active_term_out(active_term_out)
  );

endmodule

FILE: hdl/tcse_front.sv
// Command front end: accepts and classifies commands for the queue.
`timescale 1ns / 1ps
module tcse_front #(
  parameter int TERMINALS = tcse_pkg::TERMINALS_DEF,
  parameter int COLUMNS   = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcse_pkg::ROWS_DEF
) (
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        cmd,
  input  logic [7:0]        char_code,
  input  logic [3:0]        terminal_sel,
  input  logic [7:0]        color_value,
  input  logic [7:0]        line_count,
  input  logic [4:0]        read_row,
  input  logic [6:0]        read_col,
  output logic              push,
  output tcse_pkg::item_t   item
);

  assign push = start && !busy;

  always_comb begin
    item = '0;
    case (cmd)
      tcse_pkg::CMD_PUT:    item.op = tcse_pkg::OP_PUT;
      tcse_pkg::CMD_SWITCH: item.op = tcse_pkg::OP_SWITCH;
      tcse_pkg::CMD_COLOR:  item.op = tcse_pkg::OP_COLOR;
      tcse_pkg::CMD_CLEAR:  item.op = tcse_pkg::OP_CLEAR;
      tcse_pkg::CMD_UP:     item.op = tcse_pkg::OP_UP;
      tcse_pkg::CMD_DOWN:   item.op = tcse_pkg::OP_DOWN;
      tcse_pkg::CMD_READ:   item.op = tcse_pkg::OP_READ;
      default:              item.op = tcse_pkg::OP_NOP;
    endcase
    case (char_code)
      tcse_pkg::CHAR_NL:  item.kind = tcse_pkg::CK_NL;
      tcse_pkg::CHAR_CR:  item.kind = tcse_pkg::CK_CR;
      tcse_pkg::CHAR_TAB: item.kind = tcse_pkg::CK_TAB;
      tcse_pkg::CHAR_BS:  item.kind = tcse_pkg::CK_BS;
      default:            item.kind = tcse_pkg::CK_PRINT;
    endcase
    item.ch     = char_code;
    item.sel    = terminal_sel;
    item.sel_ok = 32'(terminal_sel) < TERMINALS;
    item.color  = color_value;
    item.lines  = line_count;
    item.row    = read_row;
    item.col    = read_col;
    item.rd_in  = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
  end

endmodule

FILE: hdl/tcse_queue.sv
// Two-entry command queue between front end and executor.
`timescale 1ns / 1ps
module tcse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcse_pkg::item_t item_in,
  input  logic            pop,
  output tcse_pkg::item_t item_out,
  output logic            not_empty,
  output logic            full
);

  tcse_pkg::item_t slot [2];
  logic            wp;
  logic            rp;
  logic [1:0]      count;

  assign item_out  = slot[rp];
  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue underflow");

endmodule

FILE: hdl/tcse_back.sv
// Command executor: terminal state, cell store and result generation.
`timescale 1ns / 1ps
module tcse_back #(
  parameter int TERMINALS    = tcse_pkg::TERMINALS_DEF,
  parameter int COLUMNS      = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS         = tcse_pkg::ROWS_DEF,
  parameter int STORED_LINES = tcse_pkg::STORED_LINES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  tcse_pkg::item_t q_item,
  output logic            q_pop,
  output logic            init_busy,
  output logic            done,
  output logic [15:0]     cell_word,
  output logic [6:0]      view_start_row,
  output logic [6:0]      cursor_col_out,
  output logic [4:0]      cursor_row_out,
  output logic            cursor_hidden,
  output logic [3:0]      active_term_out
);

  localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int LW = $clog2(STORED_LINES);
  localparam int CW = $clog2(COLUMNS);
  localparam int AW = TW + LW + CW;
  localparam int SW = ((LW > 8) ? LW : 8) + 1;

  tcse_pkg::state_t state, state_next;
  tcse_pkg::item_t  it;

  logic [TW-1:0] act;
  logic [CW-1:0] cur_col  [TERMINALS];
  logic [LW-1:0] cur_line [TERMINALS];
  logic [LW-1:0] vofs     [TERMINALS];
  logic [LW-1:0] top      [TERMINALS];
  logic [7:0]    colour   [TERMINALS];

  logic [LW-1:0] lcnt;
  logic [CW-1:0] ccnt;
  logic [LW-1:0] blank_row;
  logic [AW-1:0] icnt;
  logic [15:0]   cell_q;
  logic          rd_ok;

  logic [15:0]   mem [2**AW];
  logic [15:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [CW-1:0] t_col;
  logic [LW-1:0] t_line;
  logic [LW-1:0] t_vo;
  logic [LW-1:0] t_top;
  logic [7:0]    t_clr;
  logic [15:0]   blank;
  logic [LW-1:0] base;
  logic [LW-1:0] vs;
  logic [CW:0]   col_n;
  logic          line_inc;
  logic [LW:0]   line_n;
  logic          full_store;
  logic [LW-1:0] line_phys;
  logic [LW:0]   line_rd;
  logic          rd_hit;
  logic [SW-1:0] up_sum;
  logic [LW-1:0] up_val;
  logic [LW-1:0] down_val;
  logic          last_col;
  logic          last_line;

  function automatic logic [LW-1:0] wrap_line(input logic [LW:0] l, input logic [LW-1:0] tp);
    logic [LW+1:0] s;
    s = (LW+2)'(l) + (LW+2)'(tp);
    if (32'(s) >= STORED_LINES) s = s - (LW+2)'(STORED_LINES);
    return s[LW-1:0];
  endfunction

  assign t_col  = cur_col[act];
  assign t_line = cur_line[act];
  assign t_vo   = vofs[act];
  assign t_top  = top[act];
  assign t_clr  = colour[act];
  assign blank  = {t_clr, tcse_pkg::CHAR_BLANK};

  assign init_busy = state == tcse_pkg::ST_INIT;
  assign last_col  = ccnt == CW'(COLUMNS - 1);
  assign last_line = lcnt == LW'(STORED_LINES - 1);

  always_comb begin
    if (32'(t_line) < ROWS) base = '0;
    else base = LW'(32'(t_line) - ROWS + 1);
    vs = (base >= t_vo) ? base - t_vo : '0;
  end

  // put char column/line update
  always_comb begin
    col_n    = {1'b0, t_col};
    line_inc = 1'b0;
    case (it.kind)
      tcse_pkg::CK_NL: begin
        col_n    = '0;
        line_inc = 1'b1;
      end
      tcse_pkg::CK_CR:  col_n = '0;
      tcse_pkg::CK_TAB: col_n = ({1'b0, t_col} + (CW+1)'(4)) & ~(CW+1)'(3);
      tcse_pkg::CK_BS:  if (t_col != '0) col_n = {1'b0, t_col} - 1'b1;
      default:          col_n = {1'b0, t_col} + 1'b1;
    endcase
    if (32'(col_n) >= COLUMNS) begin
      col_n    = '0;
      line_inc = 1'b1;
    end
    line_n     = {1'b0, t_line} + (LW+1)'(line_inc);
    full_store = 32'(line_n) >= STORED_LINES;
    line_phys  = wrap_line({1'b0, t_line}, t_top);
  end

  always_comb begin
    line_rd  = {1'b0, vs} + (LW+1)'(it.row);
    rd_hit   = it.rd_in && (32'(line_rd) < STORED_LINES);
    up_sum   = SW'(t_vo) + SW'(it.lines);
    up_val   = (up_sum > SW'(base)) ? base : LW'(up_sum);
    down_val = (SW'(t_vo) >= SW'(it.lines)) ? LW'(SW'(t_vo) - SW'(it.lines)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tcse_pkg::ST_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = blank;
    mem_re     = 1'b0;
    mem_raddr  = {act, wrap_line(line_rd, t_top), it.col[CW-1:0]};
    case (state)
      tcse_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = icnt;
        mem_wdata = tcse_pkg::RESET_CELL;
        if (&icnt) state_next = tcse_pkg::ST_IDLE;
      end
      tcse_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = tcse_pkg::ST_EXEC;
        end
      end
      tcse_pkg::ST_EXEC: begin
        state_next = tcse_pkg::ST_RESP;
        case (it.op)
          tcse_pkg::OP_PUT: begin
            if (it.kind == tcse_pkg::CK_PRINT) begin
              mem_we    = 1'b1;
              mem_waddr = {act, line_phys, t_col};
              mem_wdata = {t_clr, it.ch};
            end else if (it.kind == tcse_pkg::CK_BS && t_col != '0) begin
              mem_we    = 1'b1;
              mem_waddr = {act, line_phys, t_col - 1'b1};
            end
            if (full_store) state_next = tcse_pkg::ST_BLANK;
          end
          tcse_pkg::OP_CLEAR: state_next = tcse_pkg::ST_CLEAR;
          tcse_pkg::OP_READ: begin
            mem_re     = rd_hit;
            state_next = tcse_pkg::ST_READW;
          end
          default: ;
        endcase
      end
      tcse_pkg::ST_READW: state_next = tcse_pkg::ST_RESP;
      tcse_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {act, blank_row, ccnt};
        if (last_col) state_next = tcse_pkg::ST_RESP;
      end
      tcse_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {act, lcnt, ccnt};
        if (last_col && last_line) state_next = tcse_pkg::ST_RESP;
      end
      tcse_pkg::ST_RESP: state_next = tcse_pkg::ST_IDLE;
      default: state_next = tcse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) it <= q_item;
    case (state)
      tcse_pkg::ST_EXEC: begin
        cell_q    <= '0;
        rd_ok     <= rd_hit;
        ccnt      <= '0;
        lcnt      <= '0;
        blank_row <= t_top;
      end
      tcse_pkg::ST_READW: cell_q <= rd_ok ? rdata : '0;
      tcse_pkg::ST_BLANK: ccnt <= ccnt + 1'b1;
      tcse_pkg::ST_CLEAR: begin
        if (last_col) begin
          ccnt <= '0;
          lcnt <= lcnt + 1'b1;
        end else begin
          ccnt <= ccnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= '0;
      icnt <= '0;
      done <= 1'b0;
      for (int i = 0; i < TERMINALS; i++) begin
        cur_col[i]  <= '0;
        cur_line[i] <= '0;
        vofs[i]     <= '0;
        top[i]      <= '0;
        colour[i]   <= tcse_pkg::RESET_COLOUR;
      end
    end else begin
      done <= state == tcse_pkg::ST_RESP;
      if (state == tcse_pkg::ST_INIT) icnt <= icnt + 1'b1;
      if (state == tcse_pkg::ST_EXEC) begin
        case (it.op)
          tcse_pkg::OP_PUT: begin
            vofs[act]    <= '0;
            cur_col[act] <= CW'(col_n);
            if (full_store) begin
              cur_line[act] <= LW'(STORED_LINES - 1);
              top[act]      <= (t_top == LW'(STORED_LINES - 1)) ? '0 : t_top + 1'b1;
            end else begin
              cur_line[act] <= LW'(line_n);
            end
          end
          tcse_pkg::OP_SWITCH: if (it.sel_ok) act <= TW'(it.sel);
          tcse_pkg::OP_COLOR:  colour[act] <= it.color;
          tcse_pkg::OP_CLEAR: begin
            cur_col[act]  <= '0;
            cur_line[act] <= '0;
            vofs[act]     <= '0;
            top[act]      <= '0;
          end
          tcse_pkg::OP_UP:   vofs[act] <= up_val;
          tcse_pkg::OP_DOWN: vofs[act] <= down_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcse_pkg::ST_RESP) begin
      cell_word       <= cell_q;
      view_start_row  <= 7'(vs);
      cursor_hidden   <= t_vo != '0;
      cursor_col_out  <= (t_vo != '0) ? '0 : 7'(t_col);
      cursor_row_out  <= (t_vo != '0) ? '0 : 5'(t_line - vs);
      active_term_out <= 4'(act);
    end
  end

  a_done_after_resp: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == tcse_pkg::ST_RESP))
    else $error("result strobe without response state");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == tcse_pkg::ST_IDLE) |-> !mem_we)
    else $error("cell store written while idle");
  a_offset_clamped: assert property (@(posedge clk) disable iff (rst)
    (state != tcse_pkg::ST_INIT) |-> (t_vo <= base))
    else $error("view offset beyond scrollback");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(t_col) < COLUMNS)
    else $error("cursor column out of range");

endmodule
